/* sv/cdq_pkg.sv */
// Shared types and request codes for the circular deque unit.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned CAP_W = 11;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [VAL_W-1:0] push_value;
  } cdq_in_t;

  typedef struct packed {
    logic             accepted;
    logic [VAL_W-1:0] front_value;
    logic [VAL_W-1:0] rear_value;
    logic             ends_valid;
    logic             is_empty;
    logic             is_full;
  } cdq_out_t;

endpackage

/* sv/circular_deque_unit.sv */
// Top level of the circular deque: request sequencer, end caches and result queue.
`timescale 1ns / 1ps

//  channel | ports                              | payload
//  --------+------------------------------------+------------------------
//  request | in_valid, in_ready, in_data        | cdq_in_t (type, value)
//  result  | out_valid, out_ready, out_data     | cdq_out_t (flags, ends)
//  config  | cfg_we, cfg_wdata                  | capacity, 11 bits
//
// A push, a status or unknown request, a refused pop and a pop that empties the
// deque finish when taken; a pop that leaves elements first goes through S_READ
// to fetch the new end from the slot memory. The result is registered.
// Reset empties the deque; slot contents stay undefined, no clearing pass.
// With the output register stalled, one more result can wait in a holding
// register; while that register is occupied the request side stalls.

module circular_deque_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdq_pkg::cdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::cdq_out_t out_data,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata
);

  import cdq_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [AW-1:0]         rear_r, rear_nxt;
  logic [DATA_WIDTH-1:0] fcache_r, fcache_nxt;
  logic [DATA_WIDTH-1:0] rcache_r, rcache_nxt;
  logic                  ok_r, ok_nxt;
  logic                  rd_front_r, rd_front_nxt;
  cdq_out_t              out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cdq_out_t              hold_r, hold_nxt;
  logic                  hold_valid_r, hold_valid_nxt;

  logic                  in_fire, out_fire;
  logic                  fin;
  cdq_out_t              fin_data;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] push_data, rd_data;
  logic [63:0]           push_wide;

  // ring index arithmetic over the effective capacity
  function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] k,
                                             input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] k1;
    k1 = CNT_W'(k) + CNT_W'(1);
    return (k1 >= cap) ? '0 : k1[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] k,
                                              input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] c1;
    c1 = cap - CNT_W'(1);
    return (k == '0) ? c1[AW-1:0] : k - AW'(1);
  endfunction

  function automatic logic [VAL_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[VAL_W-1:0];
  endfunction

  // capacity write: zero reads as one, above depth saturates
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (32'(v) > 32'(DEPTH)) begin
      return CNT_W'(32'(DEPTH));
    end else begin
      return CNT_W'(v);
    end
  endfunction

  assign in_ready  = (state_r == S_IDLE) && !hold_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign push_wide = 64'(in_data.push_value);
  assign push_data = push_wide[DATA_WIDTH-1:0];

  // request decode and state update
  always_comb begin
    state_nxt    = state_r;
    cap_nxt      = cap_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    fcache_nxt   = fcache_r;
    rcache_nxt   = rcache_r;
    ok_nxt       = ok_r;
    rd_front_nxt = rd_front_r;
    fin          = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = front_r;
    rd_en        = 1'b0;
    rd_addr      = front_r;

    if (cfg_we) begin
      cap_nxt   = eff_cap(cfg_wdata);
      count_nxt = '0;
      front_nxt = '0;
      rear_nxt  = '0;
    end else if (state_r == S_READ) begin
      // new end arrives from the slot memory
      if (rd_front_r) begin
        fcache_nxt = rd_data;
      end else begin
        rcache_nxt = rd_data;
      end
      fin       = 1'b1;
      state_nxt = S_IDLE;
    end else if (in_fire) begin
      ok_nxt = 1'b0;
      fin    = 1'b1;
      case (in_data.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          if (count_r < cap_r) begin
            ok_nxt    = 1'b1;
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (count_r == '0) begin
              rear_nxt   = front_r;
              wr_addr    = front_r;
              fcache_nxt = push_data;
              rcache_nxt = push_data;
            end else if (in_data.req_type == REQ_PUSH_FRONT) begin
              front_nxt  = step_back(front_r, cap_r);
              wr_addr    = front_nxt;
              fcache_nxt = push_data;
            end else begin
              rear_nxt   = step_fwd(rear_r, cap_r);
              wr_addr    = rear_nxt;
              rcache_nxt = push_data;
            end
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (count_r != '0) begin
            ok_nxt    = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              rear_nxt = front_r;
            end else begin
              // fetch the value at the new end before reporting
              fin       = 1'b0;
              rd_en     = 1'b1;
              state_nxt = S_READ;
              if (in_data.req_type == REQ_POP_FRONT) begin
                front_nxt    = step_fwd(front_r, cap_r);
                rd_addr      = front_nxt;
                rd_front_nxt = 1'b1;
              end else begin
                rear_nxt     = step_back(rear_r, cap_r);
                rd_addr      = rear_nxt;
                rd_front_nxt = 1'b0;
              end
            end
          end
        end
        REQ_STATUS: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // result fields from the state after the step
  always_comb begin
    fin_data.accepted    = ok_nxt;
    fin_data.ends_valid  = (count_nxt != '0);
    fin_data.is_empty    = (count_nxt == '0);
    fin_data.is_full     = (count_nxt == cap_nxt);
    fin_data.front_value = (count_nxt != '0) ? to_field(fcache_nxt) : '0;
    fin_data.rear_value  = (count_nxt != '0) ? to_field(rcache_nxt) : '0;
  end

  // output register with one holding slot behind it
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    if (fin) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = fin_data;
        out_valid_nxt = 1'b1;
      end else begin
        hold_nxt       = fin_data;
        hold_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      if (hold_valid_r) begin
        out_nxt        = hold_r;
        hold_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= eff_cap(CAP_W'(1024));
      count_r      <= '0;
      front_r      <= '0;
      rear_r       <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      count_r      <= count_nxt;
      front_r      <= front_nxt;
      rear_r       <= rear_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
    fcache_r   <= fcache_nxt;
    rcache_r   <= rcache_nxt;
    ok_r       <= ok_nxt;
    rd_front_r <= rd_front_nxt;
    out_r      <= out_nxt;
    hold_r     <= hold_nxt;
  end

  cdq_slot_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* sv/cdq_slot_ram.sv */
// Slot storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module cdq_slot_ram #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* bench/deque_checker.sv */
// Deque checker: tracks deque state per request transaction and checks every result.
`timescale 1ns / 1ps

module deque_checker #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  cdq_pkg::cdq_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  cdq_pkg::cdq_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]     cfg_wdata,
  output int unsigned                   awaiting,
  output int unsigned                   fail_count
);

  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // Shadow copy of the deque
  logic [VAL_W-1:0] slot_mem [DEPTH];
  int unsigned      head_idx;
  int unsigned      tail_idx;
  int unsigned      count;
  logic [CAP_W-1:0] cap_setting;

  // Status words still owed by the block, oldest first
  cdq_out_t         owed_status[$];

  function automatic void clear_ends();
    count    = 0;
    head_idx = 0;
    tail_idx = 0;
  endfunction

  // Apply one request to the shadow deque and return the status it reports
  function automatic cdq_out_t apply_request(input cdq_in_t req);
    int unsigned lim;
    logic        ok;
    cdq_out_t    res;
    if (cap_setting == '0) lim = 1;
    else if (32'(cap_setting) > DEPTH) lim = DEPTH;
    else lim = 32'(cap_setting);
    if (head_idx >= lim) head_idx = 0;
    if (tail_idx >= lim) tail_idx = head_idx;
    ok = 1'b0;
    case (req.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (count < lim) begin
          if (count == 0) begin
            tail_idx = head_idx;
            slot_mem[AW'(head_idx)] = req.push_value;
          end else if (req.req_type == REQ_PUSH_FRONT) begin
            head_idx = (head_idx == 0) ? lim - 1 : head_idx - 1;
            slot_mem[AW'(head_idx)] = req.push_value;
          end else begin
            tail_idx = (tail_idx + 1 >= lim) ? 0 : tail_idx + 1;
            slot_mem[AW'(tail_idx)] = req.push_value;
          end
          count++;
          ok = 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        if (count > 0) begin
          count--;
          if (count == 0) tail_idx = head_idx;
          else if (req.req_type == REQ_POP_FRONT) head_idx = (head_idx + 1 >= lim) ? 0 : head_idx + 1;
          else tail_idx = (tail_idx == 0) ? lim - 1 : tail_idx - 1;
          ok = 1'b1;
        end
      end
      REQ_STATUS: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    res.accepted    = ok;
    res.ends_valid  = (count > 0);
    res.is_empty    = (count == 0);
    res.is_full     = (count == lim);
    res.front_value = (count > 0) ? slot_mem[AW'(head_idx)] : '0;
    res.rear_value  = (count > 0) ? slot_mem[AW'(tail_idx)] : '0;
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  // Results are checked before the new request is applied; both at the same edge
  always @(posedge clk) begin
    cdq_out_t want;
    if (!rst_n) begin
      owed_status.delete();
      clear_ends();
      cap_setting = CAP_W'(1024);
    end else begin
      if (out_valid && out_ready) begin
        if (owed_status.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fail_count++;
        end else begin
          want = owed_status.pop_front();
          compare_field("accepted", VAL_W'(want.accepted), VAL_W'(out_data.accepted));
          compare_field("front_value", want.front_value, out_data.front_value);
          compare_field("rear_value", want.rear_value, out_data.rear_value);
          compare_field("ends_valid", VAL_W'(want.ends_valid), VAL_W'(out_data.ends_valid));
          compare_field("is_empty", VAL_W'(want.is_empty), VAL_W'(out_data.is_empty));
          compare_field("is_full", VAL_W'(want.is_full), VAL_W'(out_data.is_full));
        end
      end
      if (cfg_we) begin
        cap_setting = cfg_wdata;
        clear_ends();
      end
      if (in_valid && in_ready) owed_status.push_back(apply_request(in_data));
    end
    awaiting <= $unsigned(owed_status.size());
  end

endmodule

/* bench/testbench.sv */
// Testbench top: clock, reset, request and capacity stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import cdq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_STATUS + REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cdq_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cdq_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              no_gaps = 1'b0;
  int unsigned       awaiting;
  int unsigned       fail_count;
  int unsigned       idle_cycles = 0;

  circular_deque_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  deque_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .awaiting   (awaiting),
    .fail_count (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 36);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one request, with random gaps ahead of it, and hold until taken
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] value);
    while (!no_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cdq_in_t'{req_type: kind, push_value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Let the deque go idle, then write the capacity register
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Random request: pushes with the given weight, else pops, status and unused codes
  task automatic send_random(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      send_req($urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT, pick_value());
    end else begin
      roll = $urandom_range(99);
      if (roll < 80) send_req($urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT, pick_value());
      else if (roll < 92) send_req(REQ_STATUS, pick_value());
      else send_req(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), pick_value());
    end
  endtask

  // One capacity setting: optional run of pushes, then a random mix
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned fill,
                           input int unsigned mixed, input int unsigned push_pct);
    set_capacity(cap);
    repeat (fill) send_random(100);
    repeat (mixed) send_random(push_pct);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: three slots, refused pops and pushes, last-element pops, unused codes
    set_capacity(CAP_W'(3));
    send_req(REQ_STATUS, 16'h0000);
    send_req(REQ_POP_FRONT, 16'hFFFF);
    send_req(REQ_POP_REAR, 16'h0000);
    send_req(REQ_PUSH_FRONT, 16'h0000);
    send_req(REQ_PUSH_REAR, 16'hFFFF);
    send_req(REQ_PUSH_FRONT, 16'h8001);
    send_req(REQ_PUSH_REAR, 16'h1234);
    send_req(REQ_STATUS, 16'hFFFF);
    send_req(REQ_POP_FRONT, 16'h0000);
    send_req(REQ_POP_REAR, 16'h0000);
    send_req(REQ_POP_FRONT, 16'h0000);
    send_req(REQ_PUSH_REAR, 16'h7FFE);
    send_req(REQ_PUSH_FRONT, 16'h0001);
    send_req(REQ_POP_REAR, 16'h0000);
    send_req(REQ_UNUSED_FIRST, 16'hAAAA);
    send_req(REQ_UNUSED_FIRST + REQ_W'(1), 16'h5555);
    send_req(REQ_UNUSED_LAST, 16'hFFFF);
    send_req(REQ_POP_REAR, 16'h0000);
    send_req(REQ_POP_FRONT, 16'h0000);

    // Directed: single slot
    set_capacity(CAP_W'(1));
    send_req(REQ_PUSH_FRONT, 16'hC3C3);
    send_req(REQ_PUSH_REAR, 16'h3C3C);
    send_req(REQ_POP_REAR, 16'h0000);
    send_req(REQ_POP_FRONT, 16'h0000);

    // Random phases over small, zero, saturated and full-size capacities
    run_phase(CAP_W'(2), 0, 40, 55);
    run_phase(CAP_W'(0), 0, 20, 50);
    run_phase(CAP_W'(1), 0, 20, 50);
    no_gaps <= 1'b1;
    run_phase(CAP_W'(5), 0, 60, 55);
    no_gaps <= 1'b0;
    run_phase(CAP_W'(1024), 1030, 30, 40);
    run_phase(CAP_W'(2047), 0, 30, 60);
    run_phase(CAP_W'(1025), 0, 20, 60);
    run_phase(CAP_W'(7), 0, 40, 50);

    // Drain, allow for the pop path through the slot memory read, then report
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/cdq_pkg.sv
sv/cdq_slot_ram.sv
sv/circular_deque_unit.sv
bench/deque_checker.sv
bench/testbench.sv
